>>> hw/rtl/qdt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qdt_pkg: shared types and constants of the quoted delimiter tokenizer
// Word layouts of both channels, the per-byte result group and the
// delimiter match helper.
// ---------------------------------------------------------------------------
package qdt_pkg;

   // Delimiter slots per list and token counter ceiling
   localparam int MAX_DELIMS  = 4;
   localparam int MAX_TOKENS  = 255;
   localparam int DELIM_LIM   = (MAX_DELIMS < 4) ? MAX_DELIMS : 4;
   localparam logic [7:0] COUNT_LIM = 8'((MAX_TOKENS < 255) ? MAX_TOKENS : 255);

   // Depth of the result group queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Special characters
   localparam logic [7:0] BACKSLASH_CH = 8'h5C;
   localparam logic [7:0] QUOTE_CH     = 8'h22;
   localparam logic [7:0] SPACE_CH     = 8'h20;
   localparam logic [7:0] TAB_CH       = 8'h09;

   // Result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_BEGIN_DELIMS = 3'd0;
   localparam logic [2:0] REG_BEGIN_COUNT  = 3'd1;
   localparam logic [2:0] REG_END_DELIMS   = 3'd2;
   localparam logic [2:0] REG_END_COUNT    = 3'd3;
   localparam logic [2:0] REG_SKIP_WS      = 3'd4;
   localparam logic [2:0] REG_SKIP_QUOTES  = 3'd5;
   localparam logic [2:0] REG_ACCURATE_END = 3'd6;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_buffer;
   } qdt_req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [7:0] token_index;
      logic       status;
      logic       last;
   } qdt_rsp_type;

   // Configuration seen by the front end
   typedef struct packed {
      logic [31:0] begin_delims;
      logic [2:0]  begin_count;
      logic [31:0] end_delims;
      logic [2:0]  end_count;
      logic        skip_leading_ws;
      logic        skip_quotes;
      logic        accurate_end;
   } qdt_cfg_type;

   // One result inside a group
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       status;
   } qdt_ent_type;

   // All results caused by one input word (one to three)
   typedef struct packed {
      logic [1:0]       count;
      logic [7:0]       token_index;
      qdt_ent_type [2:0] ent;
   } qdt_bundle_type;

   // True when ch is among the first count bytes of list
   function automatic logic match_delim(input logic [7:0] ch, input logic [31:0] list,
                                        input logic [2:0] count);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < DELIM_LIM; i++) begin
         if ((3'(i) < count) && (list[8*i +: 8] == ch)) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

>>> hw/rtl/qdt_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qdt_csr: configuration registers
// APB-style register file holding delimiter lists and mode bits.
// ---------------------------------------------------------------------------
module qdt_csr
   import qdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output qdt_cfg_type cfg
);

   qdt_cfg_type cfg_ff;
   logic [2:0]  reg_idx;
   logic        wr_en;

   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Write registers on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.begin_delims    <= '0;
         cfg_ff.begin_count     <= '0;
         cfg_ff.end_delims      <= 32'd10;
         cfg_ff.end_count       <= 3'd1;
         cfg_ff.skip_leading_ws <= 1'b0;
         cfg_ff.skip_quotes     <= 1'b0;
         cfg_ff.accurate_end    <= 1'b0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_BEGIN_DELIMS: cfg_ff.begin_delims    <= csr_pwdata;
            REG_BEGIN_COUNT:  cfg_ff.begin_count     <= csr_pwdata[2:0];
            REG_END_DELIMS:   cfg_ff.end_delims      <= csr_pwdata;
            REG_END_COUNT:    cfg_ff.end_count       <= csr_pwdata[2:0];
            REG_SKIP_WS:      cfg_ff.skip_leading_ws <= csr_pwdata[0];
            REG_SKIP_QUOTES:  cfg_ff.skip_quotes     <= csr_pwdata[0];
            REG_ACCURATE_END: cfg_ff.accurate_end    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         REG_BEGIN_DELIMS: csr_prdata = cfg_ff.begin_delims;
         REG_BEGIN_COUNT:  csr_prdata = {29'd0, cfg_ff.begin_count};
         REG_END_DELIMS:   csr_prdata = cfg_ff.end_delims;
         REG_END_COUNT:    csr_prdata = {29'd0, cfg_ff.end_count};
         REG_SKIP_WS:      csr_prdata = {31'd0, cfg_ff.skip_leading_ws};
         REG_SKIP_QUOTES:  csr_prdata = {31'd0, cfg_ff.skip_quotes};
         REG_ACCURATE_END: csr_prdata = {31'd0, cfg_ff.accurate_end};
         default:          csr_prdata = '0;
      endcase
   end

endmodule

>>> hw/rtl/qdt_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qdt_front: byte classifier
// Accepts one word per cycle while the queue is not full, updates the token
// state and forms the group of results that the byte causes.
// ---------------------------------------------------------------------------
module qdt_front
   import qdt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  qdt_cfg_type    cfg,
   input  logic           req_valid,
   output logic           req_stall,
   input  qdt_req_type    req_payload,
   input  logic           q_full,
   output logic           q_push,
   output qdt_bundle_type q_data
);

   logic       in_token_ff, in_token_in;
   logic       token_done_ff, token_done_in;
   logic       in_quotes_ff, in_quotes_in;
   logic       skip_active_ff, skip_active_in;
   logic       skipping_blank_ff, skipping_blank_in;
   logic       backslash_odd_ff, backslash_odd_in;
   logic       started_ff, started_in;
   logic [7:0] counter_ff, counter_in;
   logic       accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept && (q_data.count != 2'd0);

   // Step the tokenizer state for the byte on the input
   always_comb begin
      logic [7:0] c;
      logic       open_any, is_end, is_begin, consumed, sa;
      logic [1:0] n;
      c         = req_payload.ch;
      open_any  = (cfg.begin_count == 3'd0);
      is_end    = match_delim(c, cfg.end_delims, cfg.end_count);
      consumed  = 1'b0;
      n         = 2'd0;
      sa        = started_ff ? skip_active_ff : cfg.skip_leading_ws;
      is_begin  = open_any ? !is_end : match_delim(c, cfg.begin_delims, cfg.begin_count);

      in_token_in       = in_token_ff;
      token_done_in     = token_done_ff;
      in_quotes_in      = in_quotes_ff;
      skip_active_in    = sa;
      skipping_blank_in = skipping_blank_ff;
      counter_in        = counter_ff;
      started_in        = 1'b1;
      backslash_odd_in  = (c == BACKSLASH_CH) ? !backslash_odd_ff : 1'b0;
      q_data            = '0;

      // Skip blanks ahead of a token
      if (sa && token_done_ff && (c == SPACE_CH || c == TAB_CH)) begin
         skipping_blank_in = 1'b1;
         consumed          = 1'b1;
      end else if (sa && skipping_blank_ff && token_done_ff) begin
         skip_active_in    = 1'b0;
         skipping_blank_in = 1'b0;
      end

      // Toggle quoting on an unescaped quote
      if (!consumed && c == QUOTE_CH && !backslash_odd_ff) begin
         in_quotes_in = !in_quotes_ff;
         if (cfg.skip_quotes) begin
            consumed = 1'b1;
         end
      end

      // Open a token, or count an empty one
      if (!consumed) begin
         if (!in_token_ff && is_begin) begin
            if (counter_ff < COUNT_LIM) counter_in = counter_ff + 8'd1;
            in_token_in   = 1'b1;
            token_done_in = 1'b0;
            if (cfg.skip_leading_ws) skip_active_in = 1'b1;
            if (!open_any) consumed = 1'b1;
         end else if (!in_token_ff && is_end && open_any) begin
            if (counter_ff < COUNT_LIM) counter_in = counter_ff + 8'd1;
            token_done_in = 1'b0;
         end
      end

      // Emit the byte or close the token
      if (!consumed) begin
         if (in_token_in && is_end && !in_quotes_in) in_token_in = 1'b0;
         if (in_token_in) begin
            q_data.ent[0] = '{kind: KIND_BYTE, data: c, status: 1'b0};
            n = 2'd1;
         end else if (!token_done_in) begin
            q_data.ent[0] = '{kind: KIND_CLOSE, data: 8'd0, status: 1'b0};
            n = 2'd1;
            token_done_in = 1'b1;
         end
      end

      // Report the buffer end and clear for the next buffer
      if (req_payload.end_of_buffer) begin
         if (in_token_in && !cfg.accurate_end) begin
            q_data.ent[n]        = '{kind: KIND_CLOSE, data: 8'd0, status: 1'b0};
            q_data.ent[n + 2'd1] = '{kind: KIND_END, data: 8'd0, status: 1'b0};
            n = n + 2'd2;
         end else begin
            q_data.ent[n] = '{kind: KIND_END, data: 8'd0, status: 1'b1};
            n = n + 2'd1;
         end
         in_token_in       = 1'b0;
         token_done_in     = 1'b1;
         in_quotes_in      = 1'b0;
         skip_active_in    = cfg.skip_leading_ws;
         skipping_blank_in = 1'b0;
         backslash_odd_in  = 1'b0;
         started_in        = 1'b0;
      end

      q_data.count       = n;
      q_data.token_index = counter_in;
      if (req_payload.end_of_buffer) counter_in = 8'd0;
   end

   // Hold state, advance on an accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff       <= 1'b0;
         token_done_ff     <= 1'b1;
         in_quotes_ff      <= 1'b0;
         skip_active_ff    <= 1'b0;
         skipping_blank_ff <= 1'b0;
         backslash_odd_ff  <= 1'b0;
         started_ff        <= 1'b0;
         counter_ff        <= '0;
      end else if (accept) begin
         in_token_ff       <= in_token_in;
         token_done_ff     <= token_done_in;
         in_quotes_ff      <= in_quotes_in;
         skip_active_ff    <= skip_active_in;
         skipping_blank_ff <= skipping_blank_in;
         backslash_odd_ff  <= backslash_odd_in;
         started_ff        <= started_in;
         counter_ff        <= counter_in;
      end
   end

endmodule

>>> hw/rtl/qdt_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qdt_queue: result group queue
// Small FIFO of result groups between the classifier and the emitter.
// ---------------------------------------------------------------------------
module qdt_queue
   import qdt_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  qdt_bundle_type push_data,
   input  logic           pop,
   output logic           full,
   output logic           not_empty,
   output qdt_bundle_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   qdt_bundle_type mem_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the group
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/qdt_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qdt_back: result emitter
// Sends the results of the head group one word at a time.
// ---------------------------------------------------------------------------
module qdt_back
   import qdt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_not_empty,
   input  qdt_bundle_type q_head,
   output logic           q_pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output qdt_rsp_type    rsp_payload
);

   logic [1:0]  pos_ff, pos_in;
   logic        is_last;
   qdt_ent_type cur;

   assign cur       = q_head.ent[pos_ff];
   assign is_last   = (pos_ff == q_head.count - 2'd1);
   assign rsp_valid = q_not_empty;
   assign q_pop     = rsp_valid && !rsp_stall && is_last;

   assign rsp_payload.kind        = cur.kind;
   assign rsp_payload.data        = cur.data;
   assign rsp_payload.token_index = q_head.token_index;
   assign rsp_payload.status      = cur.status;
   assign rsp_payload.last        = is_last;

   // Step through the group, restart on the next one
   always_comb begin
      pos_in = pos_ff;
      if (rsp_valid && !rsp_stall) begin
         pos_in = is_last ? 2'd0 : pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   a_pos_in_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pos_ff < q_head.count))
      else $error("result position beyond group size");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.kind == KIND_END) |-> rsp_payload.last)
      else $error("end report is not the final result of its word");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.kind != KIND_BYTE) |-> (rsp_payload.data == 8'd0))
      else $error("marker carries data");

   a_status_end_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.kind != KIND_END) |-> !rsp_payload.status)
      else $error("status set outside end report");

   a_pos_restart: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (pos_ff == 2'd0))
      else $error("position not restarted after group");

endmodule

>>> hw/rtl/quoted_delimiter_tokenizer.sv
`timescale 1ns / 1ps
// The results of an accepted byte are registered as one group in the queue.
// Throughput: one byte per cycle while the output does not stall and each byte gives
// at most one result; a byte with two or three results sends them one after another.
// The two-group queue sets how far the input runs ahead of a stalled output.
// Reset (synchronous): registers return to defaults, token state clears, queue empties.
// ---------------------------------------------------------------------------
// quoted_delimiter_tokenizer: top level
// Splits a byte stream into tokens with quote and escape handling.
// ---------------------------------------------------------------------------
module quoted_delimiter_tokenizer
   import qdt_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  qdt_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output qdt_rsp_type rsp_payload,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   qdt_cfg_type    cfg;
   logic           q_push, q_pop, q_full, q_not_empty;
   qdt_bundle_type q_data, q_head;

   qdt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   qdt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_data)
   );

   qdt_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   qdt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
